// File: hdl/rxbc_pkg.sv
package rxbc_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 8;
   localparam int unsigned CSR_DATA_WIDTH  = 64;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CIPHER_TYPE    = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ENCRYPT_MODE   = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RAW_KEY        = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MESSAGE_LENGTH = 8'd3;

   localparam logic [6:0] BLOCK_MASK_SHORT = 7'h3f;
   localparam logic [6:0] BLOCK_MASK_LONG  = 7'h7f;

   // Key-stream byte lane (shift / 8) for each cipher type.
   localparam logic [2:0] POS_LANE [8] = '{3'd0, 3'd5, 3'd3, 3'd1, 3'd4, 3'd7, 3'd2, 3'd6};
   localparam logic [2:0] KEY_LANE [8] = '{3'd7, 3'd4, 3'd6, 3'd2, 3'd5, 3'd0, 3'd1, 3'd3};

   // Key derivation rounds: moved lane, left and right shifts, copied lane.
   localparam logic [2:0] SRC_LANE [8] = '{3'd7, 3'd5, 3'd3, 3'd1, 3'd0, 3'd2, 3'd4, 3'd6};
   localparam logic [5:0] SHL_AMT  [8] = '{6'd0, 6'd0, 6'd8, 6'd40, 6'd56, 6'd24, 6'd0, 6'd0};
   localparam logic [5:0] SHR_AMT  [8] = '{6'd56, 6'd24, 6'd0, 6'd0, 6'd0, 6'd0, 6'd8, 6'd40};
   localparam logic [2:0] COPY_LANE [2][8] = '{
      '{3'd0, 3'd2, 3'd4, 3'd6, 3'd7, 3'd5, 3'd3, 3'd1},
      '{3'd2, 3'd4, 3'd6, 3'd7, 3'd5, 3'd3, 3'd1, 3'd0}
   };

   typedef struct packed {
      logic        cipher_type;
      logic        encrypt_mode;
      logic [63:0] raw_key;
   } rxbc_cfg_type;

   typedef struct packed {
      logic [63:0] working_key;
      logic [63:0] feedback_bits;
      logic [2:0]  block_count;
   } rxbc_state_type;

   function automatic logic [63:0] rxbc_lane(input logic [63:0] v, input logic [2:0] k);
      return v & (64'hff << {k, 3'b000});
   endfunction

   function automatic logic [63:0] rxbc_derive_key(input logic cipher_sel,
                                                   input logic [63:0] key);
      logic [63:0] acc;
      logic [63:0] src;
      logic [63:0] moved;
      acc = '0;
      for (int r = 0; r < 8; r++) begin
         src   = (r == 0) ? key : acc;
         moved = (rxbc_lane(src, SRC_LANE[r]) << SHL_AMT[r]) >> SHR_AMT[r];
         acc   = (moved ^ rxbc_lane(key, COPY_LANE[cipher_sel][r])) | acc;
      end
      return acc;
   endfunction

endpackage

// File: hdl/rxbc_datapath.sv
module rxbc_datapath
   import rxbc_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = 24
) (
   input  rxbc_cfg_type           cfg,
   input  logic [LENGTH_BITS-1:0] message_length,
   input  rxbc_state_type         state,
   input  logic [LENGTH_BITS-1:0] position,
   input  logic [7:0]             data_byte,
   output rxbc_state_type         state_in,
   output logic [LENGTH_BITS-1:0] position_in,
   output logic [7:0]             result_byte,
   output logic                   message_end
);

   logic                   start;
   logic [63:0]            key_a;
   logic [63:0]            fb_a;
   logic [2:0]             bc_a;
   logic [6:0]             head;
   logic                   in_head;
   logic [6:0]             diff;
   logic [6:0]             idx;
   logic                   block_start;
   logic [63:0]            key_b;
   logic [63:0]            fb_b;
   logic [2:0]             bc_b;
   logic [2:0]             bit_sel;
   logic [2:0]             lane_sel;
   logic [7:0]             fb_byte;
   logic [63:0]            fb_add;
   logic [LENGTH_BITS-1:0] pos_inc;

   always_comb begin
      start   = (position == '0);
      key_a   = start ? rxbc_derive_key(cfg.cipher_type, cfg.raw_key) : state.working_key;
      fb_a    = start ? 64'd0 : state.feedback_bits;
      bc_a    = start ? 3'd0 : state.block_count;

      head    = message_length[6:0] & (cfg.cipher_type ? BLOCK_MASK_LONG : BLOCK_MASK_SHORT);
      in_head = (position < LENGTH_BITS'(head));
      diff    = position[6:0] - head;
      if (in_head) begin
         idx = position[6:0];
      end else begin
         idx = diff & (cfg.cipher_type ? BLOCK_MASK_LONG : BLOCK_MASK_SHORT);
      end
      block_start = !in_head && (idx == 7'd0);

      key_b   = block_start ? (key_a ^ fb_a) : key_a;
      fb_b    = block_start ? 64'd0 : fb_a;
      bc_b    = block_start ? (bc_a + 3'd1) : bc_a;
      bit_sel = in_head ? 3'd0 : bc_b;

      lane_sel    = cfg.cipher_type ? KEY_LANE[key_b[2:0]] : POS_LANE[position[2:0]];
      result_byte = data_byte ^ key_b[{lane_sel, 3'b000} +: 8];
      fb_byte     = cfg.encrypt_mode ? result_byte : data_byte;
      fb_add      = {56'd0, fb_byte & (8'd1 << bit_sel)} << idx[5:0];

      state_in.working_key   = key_b;
      state_in.feedback_bits = fb_b | fb_add;
      state_in.block_count   = bc_b;

      pos_inc     = position + LENGTH_BITS'(1);
      message_end = (pos_inc == message_length);
      position_in = message_end ? '0 : pos_inc;
   end

endmodule

// File: hdl/rekeyed_xor_byte_cipher_top.sv
// Byte stream cipher that re-keys itself at every block boundary.
// Input words arrive on the req_ stream, one message byte in req_tdata.
// Result words leave on the rsp_ stream: the ciphered byte in rsp_tdata,
// and rsp_tlast marks the last byte of a message of message_length bytes.
// The csr_ port writes cipher_type, encrypt_mode, raw_key and message_length
// by index; it is always ready, and writes belong between messages.
// Each byte is processed in the cycle it is accepted and its result is
// registered; one byte is taken per cycle while the receiver does not stall.
// The working key is derived from raw_key during the first byte of a message,
// so no separate setup step is needed.
// When the receiver stalls, the result register holds and req_tready drops
// until the result word is taken; a word is taken in the same cycle as the
// held result leaves.
// Reset clears the configuration, the key state, the byte position and the
// result valid flag, so the next byte starts a new message.
module rekeyed_xor_byte_cipher_top
   import rxbc_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // data_byte
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,   // result_byte
   output logic                       rsp_tlast,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   rxbc_cfg_type           cfg_ff;
   logic [LENGTH_BITS-1:0] length_ff;
   rxbc_state_type         state_ff;
   rxbc_state_type         state_in;
   logic [LENGTH_BITS-1:0] pos_ff;
   logic [LENGTH_BITS-1:0] pos_in;
   logic [7:0]             result_in;
   logic                   last_in;
   logic                   rsp_valid_ff;
   logic [7:0]             rsp_data_ff;
   logic                   rsp_last_ff;
   logic                   req_accept;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   rxbc_datapath #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_datapath (
      .cfg           (cfg_ff),
      .message_length(length_ff),
      .state         (state_ff),
      .position      (pos_ff),
      .data_byte     (req_tdata),
      .state_in      (state_in),
      .position_in   (pos_in),
      .result_byte   (result_in),
      .message_end   (last_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff    <= '0;
         length_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CIPHER_TYPE:    cfg_ff.cipher_type  <= csr_data[0];
            CSR_ENCRYPT_MODE:   cfg_ff.encrypt_mode <= csr_data[0];
            CSR_RAW_KEY:        cfg_ff.raw_key      <= csr_data;
            CSR_MESSAGE_LENGTH: length_ff           <= csr_data[LENGTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            state_ff <= state_in;
            pos_ff   <= pos_in;
         end
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= result_in;
         rsp_last_ff <= last_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_tvalid)
      else $error("accepted word produced no result");

   assert property (@(posedge clock) disable iff (reset)
      (req_accept && last_in) |=> (pos_ff == '0))
      else $error("byte position did not return to zero at message end");

   assert property (@(posedge clock) disable iff (reset)
      (req_accept && !last_in) |=> (pos_ff == $past(pos_ff) + LENGTH_BITS'(1)))
      else $error("byte position did not advance by one");

   assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> ($stable(state_ff) && $stable(pos_ff)))
      else $error("key state changed without an accepted word");

endmodule

// File: bench/tb_rekeyed_xor_byte_cipher_top.sv
`timescale 1ns / 100ps

module tb_rekeyed_xor_byte_cipher_top;
   import rxbc_pkg::*;

   localparam int unsigned HALF_PERIOD = 5;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned LONG_HOLD   = 120;
   localparam int unsigned ITEM_TARGET = 550;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED_TOP   = 8'hff;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED_FIRST = CSR_MESSAGE_LENGTH + 8'd1;
   localparam logic [23:0] LENGTH_MAX = 24'hff_ffff;

   // Byte lane of the working key that supplies the key-stream byte.
   localparam int LANE_BY_POS [8] = '{0, 5, 3, 1, 4, 7, 2, 6};
   localparam int LANE_BY_KEY [8] = '{7, 4, 6, 2, 5, 0, 1, 3};
   // Key schedule: each round moves one byte lane and folds in one lane of the raw key.
   localparam int MIX_FROM [8] = '{7, 5, 3, 1, 0, 2, 4, 6};
   localparam int MIX_TO   [8] = '{0, 2, 4, 6, 7, 5, 3, 1};
   localparam int MIX_COPY [2][8] = '{
      '{0, 2, 4, 6, 7, 5, 3, 1},
      '{2, 4, 6, 7, 5, 3, 1, 0}
   };

   typedef struct packed {
      logic [7:0] cipher_byte;
      logic       msg_end;
   } cipher_word_t;

   class xor_stream_predictor;
      bit          cipher_type;
      bit          encrypt_mode;
      bit [63:0]   raw_key;
      bit [23:0]   msg_len;
      bit [63:0]   work_key;
      bit [63:0]   fb_bits;
      bit [23:0]   pos;
      bit [2:0]    blk_cnt;
      cipher_word_t expected_words[$];
      int unsigned failures;

      function void write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [63:0] value);
         case (idx)
            CSR_CIPHER_TYPE: begin
               cipher_type = value[0];
            end
            CSR_ENCRYPT_MODE: begin
               encrypt_mode = value[0];
            end
            CSR_RAW_KEY: begin
               raw_key = value;
            end
            CSR_MESSAGE_LENGTH: begin
               msg_len = value[23:0];
            end
            default: begin
            end
         endcase
      endfunction

      function bit [63:0] mix_key(bit sel, bit [63:0] key);
         bit [63:0] acc;
         bit [63:0] term;
         bit [7:0]  moved;
         acc = '0;
         for (int r = 0; r < 8; r++) begin
            moved = (r == 0) ? key[8*MIX_FROM[r] +: 8] : acc[8*MIX_FROM[r] +: 8];
            term = '0;
            term[8*MIX_TO[r] +: 8] = moved;
            term[8*MIX_COPY[sel][r] +: 8] ^= key[8*MIX_COPY[sel][r] +: 8];
            acc |= term;
         end
         return acc;
      endfunction

      function int unsigned bytes_left();
         bit [23:0] d;
         d = msg_len - pos - 24'd1;
         return int'(d) + 1;
      endfunction

      function void note_byte(bit [7:0] din);
         int unsigned blk;
         int unsigned lane_no;
         bit [23:0]   head;
         bit [23:0]   idx24;
         bit [6:0]    idx;
         bit [2:0]    bitsel;
         bit [7:0]    outb;
         bit [7:0]    fbyte;
         bit          last;
         blk = cipher_type ? 128 : 64;
         head = msg_len & 24'(blk - 1);
         if (pos == 24'd0) begin
            work_key = mix_key(cipher_type, raw_key);
            fb_bits = '0;
            blk_cnt = '0;
         end
         if (pos < head) begin
            idx = pos[6:0];
            bitsel = 3'd0;
         end else begin
            idx24 = (pos - head) & 24'(blk - 1);
            idx = idx24[6:0];
            if (idx == 7'd0) begin
               work_key ^= fb_bits;
               fb_bits = '0;
               blk_cnt++;
            end
            bitsel = blk_cnt;
         end
         lane_no = cipher_type ? LANE_BY_KEY[work_key[2:0]] : LANE_BY_POS[pos[2:0]];
         outb = din ^ work_key[8*lane_no +: 8];
         fbyte = encrypt_mode ? outb : din;
         fb_bits |= {56'd0, fbyte & (8'd1 << bitsel)} << idx[5:0];
         last = (pos + 24'd1) == msg_len;
         pos = last ? 24'd0 : pos + 24'd1;
         expected_words.push_back('{outb, last});
      endfunction

      function void check_word(logic [7:0] cipher_byte, logic msg_end);
         cipher_word_t exp_w;
         if (expected_words.size() == 0) begin
            $error("unexpected result word: result_byte %h message_end %b",
                   cipher_byte, msg_end);
            failures++;
         end else begin
            exp_w = expected_words.pop_front();
            if (cipher_byte !== exp_w.cipher_byte) begin
               $error("result_byte expected %h actual %h", exp_w.cipher_byte, cipher_byte);
               failures++;
            end
            if (msg_end !== exp_w.msg_end) begin
               $error("message_end expected %b actual %b", exp_w.msg_end, msg_end);
               failures++;
            end
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [7:0]                 req_tdata;   // data_byte
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [7:0]                 rsp_tdata;   // result_byte
   logic                       rsp_tlast;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_data;

   xor_stream_predictor predictor;
   bit          quiet;
   bit          hold_request;
   int unsigned cycle_count;

   rekeyed_xor_byte_cipher_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("rekeyed_xor_byte_cipher_top verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         predictor.check_word(rsp_tdata, rsp_tlast);
      end
   end

   // The receiver stalls at random, and holds off for a long stretch when asked.
   initial begin : receiver
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (!quiet && $urandom_range(0, 99) < 12) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                      : $urandom_range(1, 3);
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      predictor.write_reg(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_byte(input logic [7:0] value);
      int unsigned gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 99) < 15) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      predictor.note_byte(value);
      @(negedge clock);
   endtask

   task automatic send_random_bytes(input int unsigned count);
      repeat (count) send_byte(8'($urandom));
   endtask

   // Called at a falling edge; returns once every expected word has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (predictor.expected_words.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [63:0] pick_key();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         return 64'd0;
      end else if (sel == 1) begin
         return '1;
      end
      return {$urandom, $urandom};
   endfunction

   function automatic logic [23:0] pick_length();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
         return 24'($urandom_range(1, 130));
      end else if (sel < 85) begin
         return 24'($urandom_range(131, 600));
      end else if (sel < 92) begin
         return 24'd0;
      end else if (sel < 96) begin
         return LENGTH_MAX - 24'($urandom_range(0, 3));
      end
      return 24'($urandom_range(24'h80_0000, 24'hff_ffff));
   endfunction

   initial begin : stimulus
      int unsigned sent;
      int unsigned count;
      int unsigned left;
      logic [23:0] new_len;

      predictor = new();
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      quiet = 1'b0;
      hold_request = 1'b0;
      cycle_count = 0;
      sent = 0;

      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: extreme keys and bytes, one-byte messages, zero and maximum
      // lengths, and length changes in the middle of a message.
      write_csr(CSR_UNMAPPED_TOP, '1);
      write_csr(CSR_CIPHER_TYPE, 64'hffff_ffff_ffff_fffe);
      write_csr(CSR_ENCRYPT_MODE, 64'd1);
      write_csr(CSR_RAW_KEY, '1);
      write_csr(CSR_MESSAGE_LENGTH, 64'hffff_ffff_ff00_0003);
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(8'ha5);
      drain_results();
      write_csr(CSR_CIPHER_TYPE, 64'h8000_0000_0000_0001);
      write_csr(CSR_ENCRYPT_MODE, 64'd0);
      write_csr(CSR_RAW_KEY, 64'h0123_4567_89ab_cdef);
      write_csr(CSR_MESSAGE_LENGTH, 64'd1);
      send_byte(8'h5a);
      send_byte(8'h3c);
      drain_results();
      write_csr(CSR_CIPHER_TYPE, 64'd0);
      write_csr(CSR_RAW_KEY, 64'd0);
      write_csr(CSR_MESSAGE_LENGTH, 64'd0);
      send_random_bytes(4);
      drain_results();
      write_csr(CSR_MESSAGE_LENGTH, 64'd6);
      send_random_bytes(2);
      drain_results();
      write_csr(CSR_CIPHER_TYPE, 64'd1);
      write_csr(CSR_ENCRYPT_MODE, 64'd1);
      write_csr(CSR_RAW_KEY, 64'hfedc_ba98_7654_3210);
      write_csr(CSR_MESSAGE_LENGTH, {40'd0, LENGTH_MAX});
      send_random_bytes(3);
      drain_results();
      write_csr(CSR_MESSAGE_LENGTH, 64'd5);
      send_random_bytes(2);
      drain_results();

      // The receiver holds off for a long stretch while words keep coming.
      write_csr(CSR_MESSAGE_LENGTH, 64'd0);
      hold_request = 1'b1;
      send_random_bytes(40);
      drain_results();

      while (sent < ITEM_TARGET) begin
         quiet = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 1) == 1) begin
            write_csr(CSR_CIPHER_TYPE, {$urandom, $urandom});
         end
         if ($urandom_range(0, 1) == 1) begin
            write_csr(CSR_ENCRYPT_MODE, {$urandom, $urandom});
         end
         if ($urandom_range(0, 1) == 1) begin
            write_csr(CSR_RAW_KEY, pick_key());
         end
         if ($urandom_range(0, 19) == 0) begin
            write_csr(8'($urandom_range(CSR_UNMAPPED_FIRST, CSR_UNMAPPED_TOP)),
                      {$urandom, $urandom});
         end
         if (predictor.pos == 24'd0) begin
            if ($urandom_range(0, 4) != 0) begin
               write_csr(CSR_MESSAGE_LENGTH, {$urandom, 8'd0, pick_length()});
            end
         end else if (predictor.bytes_left() > 400 && $urandom_range(0, 1) == 1) begin
            new_len = predictor.pos + 24'($urandom_range(1, 200));
            write_csr(CSR_MESSAGE_LENGTH, {40'd0, new_len});
         end

         left = predictor.bytes_left();
         if ($urandom_range(0, 3) != 0) begin
            count = (left > 400) ? 400 : left;
         end else begin
            count = $urandom_range(1, (left > 100) ? 100 : left);
         end
         if (count > ITEM_TARGET - sent) begin
            count = ITEM_TARGET - sent;
         end
         send_random_bytes(count);
         drain_results();
         sent += count;
      end

      repeat (10) @(posedge clock);
      if (predictor.expected_words.size() != 0) begin
         $error("%0d result words never arrived", predictor.expected_words.size());
         predictor.failures++;
      end
      if (predictor.failures == 0) begin
         $display("rekeyed_xor_byte_cipher_top verification clean");
      end else begin
         $display("rekeyed_xor_byte_cipher_top verification failed");
      end
      $finish;
   end

endmodule
